/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define RCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/rcc_pkg.sv */
package rcc_pkg;

    localparam int NUM_REGIONS = 16;
    localparam int ADDR_BITS   = 48;
    localparam int SIZE_BITS   = ADDR_BITS + 1;
    localparam int IDX_BITS    = 4;
    localparam int CNT_BITS    = 5;
    localparam int HOP_BITS    = (CNT_BITS > IDX_BITS) ? CNT_BITS : IDX_BITS;
    localparam int STAT_BITS   = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    localparam logic [STAT_BITS-1:0] ST_COVERED   = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_MISS      = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_MALFORMED = 2'd2;

    // one item travelling down the cell chain
    typedef struct packed {
        logic                 valid;
        logic                 is_write;
        logic [HOP_BITS-1:0]  hop;
        logic [ADDR_BITS-1:0] first;
        logic [ADDR_BITS-1:0] last;
        logic                 ok;
        logic                 hit;
    } token_t;

endpackage

/* hw/rtl/rcc_ifs.sv */
interface rcc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [rcc_pkg::IDX_BITS-1:0]  entry_index;
    logic [rcc_pkg::ADDR_BITS-1:0] entry_base;
    logic [rcc_pkg::SIZE_BITS-1:0] entry_size;
    logic [rcc_pkg::ADDR_BITS-1:0] query_addr;
    logic [rcc_pkg::SIZE_BITS-1:0] query_size;

    modport source (output valid, cmd, entry_index, entry_base, entry_size,
                    query_addr, query_size, input ready);
    modport sink   (input valid, cmd, entry_index, entry_base, entry_size,
                    query_addr, query_size, output ready);
endinterface

interface rcc_out_if;
    logic                          valid;
    logic                          ready;
    logic [rcc_pkg::STAT_BITS-1:0] status;

    modport source (output valid, status, input ready);
    modport sink   (input valid, status, output ready);
endinterface

interface rcc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rcc_pkg::CNT_BITS-1:0] region_count;

    modport source (output valid, region_count, input ready);
    modport sink   (input valid, region_count, output ready);
endinterface

/* hw/rtl/rcc_ingress.sv */
module rcc_ingress
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic [rcc_pkg::CNT_BITS-1:0] region_count,
    rcc_in_if.sink                       in_ch,
    output rcc_pkg::token_t              tok_out
);

    localparam int SUM_BITS = rcc_pkg::ADDR_BITS + 2;

    rcc_pkg::token_t tok_reg;
    rcc_pkg::token_t tok_next;

    logic                          is_write;
    logic [rcc_pkg::ADDR_BITS-1:0] first;
    logic [rcc_pkg::SIZE_BITS-1:0] len;
    logic [rcc_pkg::SIZE_BITS-1:0] len_m1;
    logic [SUM_BITS-1:0]           end_sum;

    // writes and checks share the same range arithmetic
    always_comb
    begin
        is_write = (in_ch.cmd == rcc_pkg::CMD_WRITE);
        first    = is_write ? in_ch.entry_base : in_ch.query_addr;
        len      = is_write ? in_ch.entry_size : in_ch.query_size;
        len_m1   = len - rcc_pkg::SIZE_BITS'(1);
        end_sum  = {2'b00, first} + {1'b0, len_m1};

        tok_next          = '0;
        tok_next.valid    = in_ch.valid;
        tok_next.is_write = is_write;
        tok_next.hop      = is_write
                          ? rcc_pkg::HOP_BITS'(in_ch.entry_index)
                          : rcc_pkg::HOP_BITS'(region_count);
        tok_next.first    = first;
        tok_next.last     = end_sum[rcc_pkg::ADDR_BITS-1:0];
        // empty range, or last byte past the top of the address space
        tok_next.ok       = (len != '0) && (end_sum[SUM_BITS-1:rcc_pkg::ADDR_BITS] == 2'b00);
        tok_next.hit      = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* hw/rtl/rcc_cell.sv */
module rcc_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  rcc_pkg::token_t tok_in,
    output rcc_pkg::token_t tok_out
);

    rcc_pkg::token_t tok_reg;
    rcc_pkg::token_t tok_next;

    logic [rcc_pkg::ADDR_BITS-1:0] first_reg;
    logic [rcc_pkg::ADDR_BITS-1:0] last_reg;
    logic                          ok_reg;

    logic wr_hit;
    logic active;
    logic match;

    always_comb
    begin
        // hop counts down to this cell's slot for writes, and down to zero
        // past the last counted region for checks
        wr_hit = tok_in.valid && tok_in.is_write && (tok_in.hop == '0);
        active = tok_in.valid && !tok_in.is_write && (tok_in.hop != '0);
        match  = active && ok_reg && tok_in.ok
               && (tok_in.first >= first_reg) && (tok_in.last <= last_reg);

        tok_next = tok_in;
        if (wr_hit)
        begin
            tok_next.valid = 1'b0;
        end
        if (tok_in.hop != '0)
        begin
            tok_next.hop = tok_in.hop - rcc_pkg::HOP_BITS'(1);
        end
        tok_next.hit = tok_in.hit || match;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            ok_reg  <= 1'b0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
            if (wr_hit)
            begin
                ok_reg <= tok_in.ok;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && wr_hit)
        begin
            first_reg <= tok_in.first;
            last_reg  <= tok_in.last;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* hw/rtl/region_containment_checker_top.sv */
// channel  | dir | payload
// in_ch    | in  | cmd, entry_index, entry_base, entry_size, query_addr, query_size
// out_ch   | out | status (one transaction per check, none per write)
// cfg      | in  | region_count
//
// one transaction enters per cycle unless out_ch stalls; a check result goes through
// the ingress register, one cell register per region and then the output register
// writes travel the same cell chain, so every check sees exactly the writes before it
// a stall on out_ch freezes the whole chain; in_ch.ready is low only then
// reset empties the chain and marks every region as never matching
`include "assert_macros.svh"

module region_containment_checker_top
(
    input  logic     clk,
    input  logic     rst_n,
    rcc_in_if.sink   in_ch,
    rcc_out_if.source out_ch,
    rcc_cfg_if.sink  cfg
);

    logic                          adv;
    logic [rcc_pkg::CNT_BITS-1:0]  count_reg;
    logic                          out_valid_reg;
    logic [rcc_pkg::STAT_BITS-1:0] status_reg;
    logic [rcc_pkg::STAT_BITS-1:0] status_next;
    logic                          res_valid;
    logic                          take_bad;
    logic                          take_none;
    logic                          out_bad;

    rcc_pkg::token_t chain [0:rcc_pkg::NUM_REGIONS];
    rcc_pkg::token_t tok_last;

    assign adv          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = adv;
    assign cfg.ready    = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            count_reg <= cfg.region_count;
        end
    end

    rcc_ingress u_ingress
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .region_count (count_reg),
        .in_ch        (in_ch),
        .tok_out      (chain[0])
    );

    for (genvar k = 0; k < rcc_pkg::NUM_REGIONS; k++)
    begin : g_cell
        rcc_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );
    end

    assign tok_last  = chain[rcc_pkg::NUM_REGIONS];
    assign res_valid = tok_last.valid && !tok_last.is_write;

    always_comb
    begin
        if (!tok_last.ok)
        begin
            status_next = rcc_pkg::ST_MALFORMED;
        end
        else if (tok_last.hit)
        begin
            status_next = rcc_pkg::ST_COVERED;
        end
        else
        begin
            status_next = rcc_pkg::ST_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= status_next;
        end
    end

    assign take_bad  = adv && res_valid && !tok_last.ok;
    assign take_none = adv && !res_valid;
    assign out_bad   = out_valid_reg && (status_reg == rcc_pkg::ST_MALFORMED);

    `RCC_ASSERT(a_malformed_reported, take_bad |=> out_bad, "malformed check not flagged")
    `RCC_ASSERT(a_write_silent, take_none |=> !out_valid_reg, "result produced without a check")
    `RCC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid_reg, "output valid during reset")

endmodule

/* tb/tb_region_containment_checker_top.sv */
module tb_region_containment_checker_top;

    localparam logic [63:0] TOP_ADDR       = (64'd1 << rcc_pkg::ADDR_BITS) - 64'd1;
    localparam logic [63:0] SPAN_ALL       = 64'd1 << rcc_pkg::ADDR_BITS;
    localparam logic [rcc_pkg::SIZE_BITS-1:0] FULL_SPAN = SPAN_ALL[rcc_pkg::SIZE_BITS-1:0];
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          CHAIN_DEPTH    = rcc_pkg::NUM_REGIONS + 6;
    localparam int          PHASE_ITEMS    = 180;

    typedef struct {
        logic                          cmd;
        logic [rcc_pkg::IDX_BITS-1:0]  idx;
        logic [rcc_pkg::ADDR_BITS-1:0] base;
        logic [rcc_pkg::SIZE_BITS-1:0] len;
        logic [rcc_pkg::ADDR_BITS-1:0] qaddr;
        logic [rcc_pkg::SIZE_BITS-1:0] qlen;
    } req_t;

    logic clk = 1'b0;
    logic rst_n;

    rcc_in_if  in_ch ();
    rcc_out_if out_ch ();
    rcc_cfg_if cfg_ch ();

    region_containment_checker_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    // predicted table, updated as transactions are accepted
    logic [rcc_pkg::ADDR_BITS-1:0] model_base [rcc_pkg::NUM_REGIONS];
    logic [rcc_pkg::SIZE_BITS-1:0] model_len  [rcc_pkg::NUM_REGIONS];
    logic [rcc_pkg::CNT_BITS-1:0]  model_count;

    // table as the stimulus generator sees it, ahead of the block
    logic [rcc_pkg::ADDR_BITS-1:0] gen_base [rcc_pkg::NUM_REGIONS] = '{default: '0};
    logic [rcc_pkg::SIZE_BITS-1:0] gen_len  [rcc_pkg::NUM_REGIONS] = '{default: '0};

    req_t                          req_q [$];
    logic [rcc_pkg::STAT_BITS-1:0] status_q [$];

    req_t drv_item;
    bit   drv_busy;
    int   drv_gap;
    int   stall_left;
    int   quiet_cycles;
    int   fails;
    bit   calm;

    function automatic bit span_fits(logic [rcc_pkg::ADDR_BITS-1:0] first,
                                     logic [rcc_pkg::SIZE_BITS-1:0] len);
        logic [63:0] f64;
        logic [63:0] l64;
        f64 = 64'(first);
        l64 = 64'(len);
        if (l64 == 64'd0)
            return 1'b0;
        return (l64 - 64'd1) <= (TOP_ADDR - f64);
    endfunction

    function automatic logic [rcc_pkg::STAT_BITS-1:0] covered_status(
        logic [rcc_pkg::ADDR_BITS-1:0] qa, logic [rcc_pkg::SIZE_BITS-1:0] qs);
        logic [63:0] q_first;
        logic [63:0] q_last;
        logic [63:0] r_first;
        logic [63:0] r_last;
        int          n;
        if (!span_fits(qa, qs))
            return rcc_pkg::ST_MALFORMED;
        q_first = 64'(qa);
        q_last  = q_first + 64'(qs) - 64'd1;
        n = (int'(model_count) > rcc_pkg::NUM_REGIONS) ? rcc_pkg::NUM_REGIONS
                                                       : int'(model_count);
        for (int k = 0; k < n; k++)
        begin
            if (span_fits(model_base[k], model_len[k]))
            begin
                r_first = 64'(model_base[k]);
                r_last  = r_first + 64'(model_len[k]) - 64'd1;
                if (q_first >= r_first && q_last <= r_last)
                    return rcc_pkg::ST_COVERED;
            end
        end
        return rcc_pkg::ST_MISS;
    endfunction

    function automatic void apply_request(req_t r);
        if (r.cmd == rcc_pkg::CMD_WRITE)
        begin
            if (int'(r.idx) < rcc_pkg::NUM_REGIONS)
            begin
                model_base[r.idx] = r.base;
                model_len[r.idx]  = r.len;
            end
        end
        else
            status_q.push_back(covered_status(r.qaddr, r.qlen));
    endfunction

    function automatic logic [rcc_pkg::ADDR_BITS-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[rcc_pkg::ADDR_BITS-1:0];
    endfunction

    function automatic logic [rcc_pkg::SIZE_BITS-1:0] rand_len();
        return ($urandom_range(0, 15) == 0) ? FULL_SPAN : {1'b0, rand48()};
    endfunction

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void push_write(int slot, logic [63:0] b, logic [63:0] s);
        req_t r;
        r.cmd   = rcc_pkg::CMD_WRITE;
        r.idx   = slot[rcc_pkg::IDX_BITS-1:0];
        r.base  = b[rcc_pkg::ADDR_BITS-1:0];
        r.len   = s[rcc_pkg::SIZE_BITS-1:0];
        r.qaddr = rand48();
        r.qlen  = rand_len();
        if (slot < rcc_pkg::NUM_REGIONS)
        begin
            gen_base[slot] = r.base;
            gen_len[slot]  = r.len;
        end
        req_q.push_back(r);
    endfunction

    function automatic void push_check(logic [63:0] a, logic [63:0] s);
        req_t r;
        r.cmd   = rcc_pkg::CMD_CHECK;
        r.idx   = rcc_pkg::IDX_BITS'($urandom_range(0, rcc_pkg::NUM_REGIONS - 1));
        r.base  = rand48();
        r.len   = rand_len();
        r.qaddr = a[rcc_pkg::ADDR_BITS-1:0];
        r.qlen  = s[rcc_pkg::SIZE_BITS-1:0];
        req_q.push_back(r);
    endfunction

    function automatic void rand_write(int nact);
        int          slot;
        int          form;
        logic [63:0] b;
        logic [63:0] s;
        if (nact > 0 && $urandom_range(0, 9) < 7)
            slot = $urandom_range(0, nact - 1);
        else
            slot = $urandom_range(0, rcc_pkg::NUM_REGIONS - 1);
        form = $urandom_range(0, 9);
        case (form)
            0:
            begin
                b = 64'(rand48());
                s = '0;
            end
            1:
            begin
                // near the top, some of these wrap
                b = TOP_ADDR - 64'($urandom_range(0, 4095));
                s = 64'($urandom_range(1, 8192));
            end
            2:
            begin
                b = '0;
                s = SPAN_ALL;
            end
            3:
            begin
                b = 64'(rand48());
                s = 64'(rand48());
            end
            default:
            begin
                b = 64'(rand48());
                s = 64'($urandom_range(1, 1 << 20));
            end
        endcase
        push_write(slot, b, s);
    endfunction

    function automatic void rand_check(int nact);
        int          pick;
        int          k;
        int          how;
        logic [63:0] b;
        logic [63:0] s;
        logic [63:0] off;
        logic [63:0] span;
        logic [63:0] rnd;
        pick = $urandom_range(0, 99);
        k = (nact > 0) ? $urandom_range(0, nact - 1)
                       : $urandom_range(0, rcc_pkg::NUM_REGIONS - 1);
        b = 64'(gen_base[k]);
        s = 64'(gen_len[k]);
        if (pick < 75 && span_fits(gen_base[k], gen_len[k]))
        begin
            rnd  = {$urandom, $urandom};
            off  = rnd % s;
            span = s - off;
            how  = $urandom_range(0, 2);
            rnd  = {$urandom, $urandom};
            if (how == 1)
                span = 64'd1 + rnd % span;
            else if (how == 2)
                span = 64'd1 + rnd % ((span > 64'd64) ? 64'd64 : span);
            // one byte longer, past the region end when the span ran to that end
            if (pick >= 65 && span < SPAN_ALL)
                span = span + 64'd1;
            push_check(b + off, span);
        end
        else if (pick < 85)
            push_check(64'(rand48()), 64'($urandom_range(1, 4096)));
        else if (pick < 90)
            push_check(64'(rand48()), '0);
        else if (pick < 95)
            push_check(TOP_ADDR - 64'($urandom_range(0, 15)),
                       64'($urandom_range(1, 32)));
        else
            push_check(64'(rand48()), 64'(rand_len()));
    endfunction

    task automatic settle();
        while (req_q.size() > 0 || drv_busy || status_q.size() > 0)
            @(posedge clk);
        // writes leave no result, let them clear the chain
        repeat (CHAIN_DEPTH) @(posedge clk);
    endtask

    task automatic set_count(logic [rcc_pkg::CNT_BITS-1:0] v);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.region_count <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        model_count = v;
    endtask

    task automatic run_phase(int cnt, int items, bit pause_midway);
        int nact;
        set_count(cnt[rcc_pkg::CNT_BITS-1:0]);
        nact = (cnt > rcc_pkg::NUM_REGIONS) ? rcc_pkg::NUM_REGIONS : cnt;
        for (int i = 0; i < items; i++)
        begin
            if (pause_midway && i == items / 2)
                settle();
            if ($urandom_range(0, 99) < 30)
                rand_write(nact);
            else
                rand_check(nact);
        end
        settle();
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            drv_busy = 1'b0;
            drv_gap  = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                apply_request(drv_item);
                drv_busy = 1'b0;
            end
            if (!drv_busy)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (req_q.size() > 0)
                begin
                    drv_item = req_q.pop_front();
                    in_ch.cmd         <= drv_item.cmd;
                    in_ch.entry_index <= drv_item.idx;
                    in_ch.entry_base  <= drv_item.base;
                    in_ch.entry_size  <= drv_item.len;
                    in_ch.query_addr  <= drv_item.qaddr;
                    in_ch.query_size  <= drv_item.qlen;
                    in_ch.valid       <= 1'b1;
                    drv_busy = 1'b1;
                    drv_gap  = (calm || $urandom_range(0, 99) < 55) ? 0 : pick_pause();
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (status_q.size() == 0)
                begin
                    $error("status transaction with nothing expected, actual %0d",
                           out_ch.status);
                    fails++;
                end
                else
                begin
                    logic [rcc_pkg::STAT_BITS-1:0] want;
                    want = status_q.pop_front();
                    if (out_ch.status !== want)
                    begin
                        $error("status: expected %0d, actual %0d", want, out_ch.status);
                        fails++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 15)
                    stall_left = pick_pause();
            end
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int cnt;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.cmd           = rcc_pkg::CMD_WRITE;
        in_ch.entry_index   = '0;
        in_ch.entry_base    = '0;
        in_ch.entry_size    = '0;
        in_ch.query_addr    = '0;
        in_ch.query_size    = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.region_count = '0;
        model_count         = '0;
        for (int k = 0; k < rcc_pkg::NUM_REGIONS; k++)
        begin
            model_base[k] = '0;
            model_len[k]  = '0;
        end
        drv_busy     = 1'b0;
        quiet_cycles = 0;
        fails        = 0;
        calm         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // region count still zero from reset: nothing can match
        push_check('0, 1);
        push_write(0, '0, SPAN_ALL);
        push_check(TOP_ADDR, 1);
        settle();

        set_count(rcc_pkg::CNT_BITS'(rcc_pkg::NUM_REGIONS));
        push_check('0, SPAN_ALL);
        push_check(TOP_ADDR, 1);
        push_check(TOP_ADDR, 2);
        push_check(5, '0);
        push_check(TOP_ADDR, SPAN_ALL);
        // zero-size entry disables the slot
        push_write(0, '0, '0);
        push_check('0, 1);
        push_write(1, TOP_ADDR, 1);
        push_check(TOP_ADDR, 1);
        // entry wrapping past the top never matches
        push_write(1, TOP_ADDR, 2);
        push_check(TOP_ADDR, 1);
        push_write(15, 'h1000, 'h100);
        push_check('h1000, 'h100);
        push_check('h10ff, 2);
        push_check('h0fff, 1);
        settle();

        set_count(rcc_pkg::CNT_BITS'(rcc_pkg::NUM_REGIONS - 1));
        push_check('h1000, 1);
        settle();

        // count above the table size is clipped
        set_count('1);
        push_check('h10ff, 1);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       cnt = rcc_pkg::NUM_REGIONS;
                1:       cnt = 31;
                2:       cnt = 1;
                3:       cnt = 0;
                6:       cnt = 8;
                default: cnt = $urandom_range(0, 31);
            endcase
            calm = (p == 4);
            run_phase(cnt, PHASE_ITEMS, p == 2);
        end

        if (fails == 0 && status_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
